// ===== rtl/core/blsplat_pkg.sv =====
// Shared types, constants and defaults for the bilinear lightmap splat core.
// No dependencies; every other file in rtl/core but blsplat_ram imports this package.
package blsplat_pkg;

  // Default sizes of the flux store.
  localparam int MAX_RES_DEF  = 256;
  localparam int MAX_MAPS_DEF = 8;

  // Widest store address over the legal parameter range (64 maps of 1024 x 1024).
  localparam int STORE_AW_MAX = 26;

  // Field widths.
  localparam int FLUX_W     = 40;
  localparam int LUM_W      = 24;
  localparam int COORD_W    = 20;
  localparam int FRAC_W     = 16;
  localparam int WGT1_W     = FRAC_W + 1;
  localparam int WEIGHT_W   = 2 * WGT1_W;
  localparam int RES_CFG_W  = 9;
  localparam int MAPS_CFG_W = 4;
  localparam int TAPS_W     = 3;

  // One half and one in Q16.
  localparam int HALF_Q16 = 32768;
  localparam int ONE_Q16  = 65536;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT  = 1'b1;

  // Entry queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                      op;
    logic                      enable;
    logic [2:0]                map_index;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;
    logic [LUM_W-1:0]          lum_value;
    logic [7:0]                pixel_x;
    logic [7:0]                pixel_y;
  } splat_in_t;

  typedef struct packed {
    logic [FLUX_W-1:0] flux;
    logic [TAPS_W-1:0] taps_written;
    logic              rejected;
  } splat_out_t;

  typedef enum logic [1:0] {
    ENT_NOP,
    ENT_READ,
    ENT_ADD
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t              kind;
    logic                   last;
    logic [TAPS_W-1:0]      taps;
    logic                   rej;
    logic [STORE_AW_MAX-1:0] addr;
    logic [LUM_W-1:0]       lum;
    logic [WEIGHT_W-1:0]    weight;
  } ent_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_EMIT
  } front_state_t;

endpackage

// ===== rtl/core/blsplat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// A read of the address written in the same cycle returns the old contents.
module blsplat_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/blsplat_queue.sv =====
// Short entry queue that decouples the front from the back.
// Depends on blsplat_pkg for the entry type and the depth.
module blsplat_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  blsplat_pkg::ent_t  push_ent,
  output logic               full,
  input  logic               pop,
  output blsplat_pkg::ent_t  pop_ent,
  output logic               valid
);
  import blsplat_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ent_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign pop_ent = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== rtl/core/blsplat_front.sv =====
// Front part: takes items, forms the Q16 positions and bilinear weights,
// and breaks each item into store entries. Depends on blsplat_pkg.
module blsplat_front #(
  parameter int MAX_RES  = blsplat_pkg::MAX_RES_DEF,
  parameter int MAX_MAPS = blsplat_pkg::MAX_MAPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  blsplat_pkg::splat_in_t             in_item,
  input  logic [blsplat_pkg::RES_CFG_W-1:0]  res_cfg,
  input  logic [blsplat_pkg::MAPS_CFG_W-1:0] maps_cfg,
  output logic                               ready,
  output logic                               push,
  output blsplat_pkg::ent_t                  push_ent,
  input  logic                               full
);
  import blsplat_pkg::*;

  localparam int RES_W  = $clog2(MAX_RES + 1);
  localparam int CMP_W  = (RES_W > RES_CFG_W) ? RES_W : RES_CFG_W;
  localparam int MC_W   = ($clog2(MAX_MAPS + 1) > MAPS_CFG_W) ? $clog2(MAX_MAPS + 1) : MAPS_CFG_W;
  localparam int F_W    = COORD_W + RES_W + 2;
  localparam int BASE_W = F_W - FRAC_W;
  localparam int ADDR_W = $clog2(MAX_MAPS * MAX_RES * MAX_RES);
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(MAX_RES);
  localparam logic [ADDR_W-1:0] PLANE_STRIDE = ADDR_W'(MAX_RES * MAX_RES);
  localparam logic [1:0]        TAP_LAST     = 2'd3;

  front_state_t              state_r, state_nxt;
  splat_in_t                 item_r, item_nxt;
  logic signed [BASE_W-1:0]  x0_r, x0_nxt, y0_r, y0_nxt;
  logic [FRAC_W-1:0]         fx_r, fx_nxt, fy_r, fy_nxt;
  logic                      rej_r, rej_nxt, read_r, read_nxt, splat_r, splat_nxt;
  logic [1:0]                tap_r, tap_nxt;
  logic [TAPS_W-1:0]         taps_acc_r, taps_acc_nxt;

  logic [RES_W-1:0]          eff_res;
  logic [MC_W-1:0]           eff_maps;
  logic                      map_ok, rd_oob;
  logic signed [F_W-1:0]     res_s, fx_full, fy_full;
  logic signed [BASE_W:0]    xx, yy, res_b;
  logic                      inb;
  logic [WGT1_W-1:0]         wx, wy;
  logic [ADDR_W-1:0]         tap_addr, rd_addr;

  // Register values out of range are clamped: a resolution of zero acts as one.
  always_comb begin
    if (res_cfg == '0) begin
      eff_res = RES_W'(1);
    end else if (CMP_W'(res_cfg) > CMP_W'(MAX_RES)) begin
      eff_res = RES_W'(MAX_RES);
    end else begin
      eff_res = RES_W'(res_cfg);
    end
    eff_maps = (MC_W'(maps_cfg) > MC_W'(MAX_MAPS)) ? MC_W'(MAX_MAPS) : MC_W'(maps_cfg);
  end

  assign map_ok = MC_W'(item_r.map_index) < eff_maps;
  assign rd_oob = (CMP_W'(item_r.pixel_x) >= CMP_W'(eff_res)) ||
                  (CMP_W'(item_r.pixel_y) >= CMP_W'(eff_res));

  // Continuous position minus one half, in Q16.
  assign res_s   = $signed(F_W'(eff_res));
  assign fx_full = F_W'(item_r.coord_u) * res_s - F_W'(HALF_Q16);
  assign fy_full = F_W'(item_r.coord_v) * res_s - F_W'(HALF_Q16);

  // Current tap: bit 0 of the tap number steps x, bit 1 steps y.
  assign xx    = (BASE_W + 1)'(x0_r) + $signed((BASE_W + 1)'(tap_r[0]));
  assign yy    = (BASE_W + 1)'(y0_r) + $signed((BASE_W + 1)'(tap_r[1]));
  assign res_b = $signed((BASE_W + 1)'(eff_res));
  assign inb   = !xx[BASE_W] && (xx < res_b) && !yy[BASE_W] && (yy < res_b);
  assign wx    = tap_r[0] ? WGT1_W'(fx_r) : WGT1_W'(ONE_Q16) - WGT1_W'(fx_r);
  assign wy    = tap_r[1] ? WGT1_W'(fy_r) : WGT1_W'(ONE_Q16) - WGT1_W'(fy_r);

  assign tap_addr = ADDR_W'(item_r.map_index) * PLANE_STRIDE +
                    ADDR_W'($unsigned(yy)) * ROW_STRIDE + ADDR_W'($unsigned(xx));
  assign rd_addr  = ADDR_W'(item_r.map_index) * PLANE_STRIDE +
                    ADDR_W'(item_r.pixel_y) * ROW_STRIDE + ADDR_W'(item_r.pixel_x);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    x0_nxt       = x0_r;
    y0_nxt       = y0_r;
    fx_nxt       = fx_r;
    fy_nxt       = fy_r;
    rej_nxt      = rej_r;
    read_nxt     = read_r;
    splat_nxt    = splat_r;
    tap_nxt      = tap_r;
    taps_acc_nxt = taps_acc_r;
    ready        = 1'b0;
    push         = 1'b0;
    push_ent     = '0;
    unique case (state_r)
      FS_IDLE: begin
        ready = 1'b1;
        if (accept) begin
          item_nxt  = in_item;
          state_nxt = FS_MUL;
        end
      end
      FS_MUL: begin
        x0_nxt       = fx_full[F_W-1:FRAC_W];
        y0_nxt       = fy_full[F_W-1:FRAC_W];
        fx_nxt       = fx_full[FRAC_W-1:0];
        fy_nxt       = fy_full[FRAC_W-1:0];
        rej_nxt      = !map_ok || (item_r.op && rd_oob);
        read_nxt     = map_ok && item_r.op && !rd_oob;
        splat_nxt    = map_ok && !item_r.op && item_r.enable;
        tap_nxt      = '0;
        taps_acc_nxt = '0;
        state_nxt    = FS_EMIT;
      end
      FS_EMIT: begin
        push = !full;
        if (splat_r) begin
          push_ent.kind   = inb ? ENT_ADD : ENT_NOP;
          push_ent.last   = (tap_r == TAP_LAST);
          push_ent.taps   = taps_acc_r + TAPS_W'(inb);
          push_ent.rej    = 1'b0;
          push_ent.addr   = STORE_AW_MAX'(tap_addr);
          push_ent.lum    = item_r.lum_value;
          push_ent.weight = WEIGHT_W'(wx) * WEIGHT_W'(wy);
        end else begin
          push_ent.kind = read_r ? ENT_READ : ENT_NOP;
          push_ent.last = 1'b1;
          push_ent.rej  = rej_r;
          push_ent.addr = STORE_AW_MAX'(rd_addr);
        end
        if (!full) begin
          tap_nxt      = tap_r + 1'b1;
          taps_acc_nxt = push_ent.taps;
          if (push_ent.last) begin
            ready = 1'b1;
            if (accept) begin
              item_nxt  = in_item;
              state_nxt = FS_MUL;
            end else begin
              state_nxt = FS_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rej_r      <= 1'b0;
      read_r     <= 1'b0;
      splat_r    <= 1'b0;
      tap_r      <= '0;
      taps_acc_r <= '0;
    end else begin
      rej_r      <= rej_nxt;
      read_r     <= read_nxt;
      splat_r    <= splat_nxt;
      tap_r      <= tap_nxt;
      taps_acc_r <= taps_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    x0_r   <= x0_nxt;
    y0_r   <= y0_nxt;
    fx_r   <= fx_nxt;
    fy_r   <= fy_nxt;
  end

endmodule

// ===== rtl/core/blsplat_back.sv =====
// Back part: owns the flux store, clears it after reset and, once clear, runs one
// read-modify-write entry per cycle. Depends on blsplat_pkg and blsplat_ram.
module blsplat_back #(
  parameter int MAX_RES  = blsplat_pkg::MAX_RES_DEF,
  parameter int MAX_MAPS = blsplat_pkg::MAX_MAPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  blsplat_pkg::ent_t      q_ent,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   out_valid,
  output blsplat_pkg::splat_out_t out_data
);
  import blsplat_pkg::*;

  localparam int DEPTH  = MAX_MAPS * MAX_RES * MAX_RES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = LUM_W + WEIGHT_W;

  logic                clearing_r, clearing_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;

  logic                r_valid_r, r_valid_nxt;
  ent_kind_t           r_kind_r;
  logic                r_last_r;
  logic [TAPS_W-1:0]   r_taps_r;
  logic                r_rej_r;
  logic [ADDR_W-1:0]   r_addr_r;
  logic [LUM_W-1:0]    r_add_r, r_add_nxt;
  logic                hit_r, hit_nxt;
  logic [FLUX_W-1:0]   fwd_r;

  logic                out_valid_r, out_valid_nxt;
  splat_out_t          out_data_r, out_data_nxt;

  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   raddr;
  logic [FLUX_W-1:0]   rdata, old_val, sum_sat;
  logic [FLUX_W:0]     sum;
  logic                upd_we, ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [FLUX_W-1:0]   ram_wdata;

  assign clearing  = clearing_r;
  assign q_pop     = q_valid && !clearing_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Issue side: read the entry's cell and scale the luminance by its weight.
  assign raddr     = q_ent.addr[ADDR_W-1:0];
  assign prod      = PROD_W'(q_ent.lum) * PROD_W'(q_ent.weight);
  assign r_add_nxt = prod[2*FRAC_W +: LUM_W];
  assign r_valid_nxt = q_pop;

  // Update side: a write to the cell read in the same cycle is forwarded.
  assign old_val = hit_r ? fwd_r : rdata;
  assign sum     = {1'b0, old_val} + (FLUX_W + 1)'(r_add_r);
  assign sum_sat = sum[FLUX_W] ? '1 : sum[FLUX_W-1:0];
  assign upd_we  = r_valid_r && (r_kind_r == ENT_ADD);
  assign hit_nxt = upd_we && q_pop && (raddr == r_addr_r);

  assign ram_we    = clearing_r || upd_we;
  assign ram_waddr = clearing_r ? clr_addr_r : r_addr_r;
  assign ram_wdata = clearing_r ? '0 : sum_sat;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt             = r_valid_r && r_last_r;
    out_data_nxt.taps_written = r_taps_r;
    out_data_nxt.rejected     = r_rej_r;
    unique case (r_kind_r)
      ENT_READ: out_data_nxt.flux = old_val;
      ENT_NOP,
      ENT_ADD:  out_data_nxt.flux = '0;
      default:  out_data_nxt.flux = '0;
    endcase
  end

  blsplat_ram #(
    .WIDTH (FLUX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      r_valid_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      r_valid_r   <= r_valid_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_kind_r   <= q_ent.kind;
    r_last_r   <= q_ent.last;
    r_taps_r   <= q_ent.taps;
    r_rej_r    <= q_ent.rej;
    r_addr_r   <= raddr;
    r_add_r    <= r_add_nxt;
    fwd_r      <= sum_sat;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/bilinear_lightmap_splat_core.sv =====
// Top level of the bilinear lightmap splat core: configuration registers,
// front, entry queue and back. Depends on blsplat_pkg and the blsplat_* modules.
//
//   Channel   Handshake              Payload        Transaction taken when
//   input     start / busy           in_data        start high, busy low
//   result    out_valid (strobe)     out_data       out_valid high, one cycle only
//   config    cfg_valid / cfg_ready  cfg_index,     cfg_valid and cfg_ready high
//                                    cfg_data
//
// In the front a splat item first has its Q16 positions formed by the two coordinate
// multipliers, then hands off one store entry per tap, since the flux store has a single
// write port and each tap is a read-modify-write. Reads, rejected items and disabled
// splats hand off a single entry. Once the store is cleared the back runs one entry a
// cycle; an item's last entry passes the queue slot, update-side registers and output
// register before the result strobe. After reset the back clears, one a cycle, all
// MAX_MAPS*MAX_RES*MAX_RES entries (524288 at the defaults) with busy held high;
// configuration writes are taken throughout. Results cannot be held off by the receiver.
module bilinear_lightmap_splat_core #(
  parameter int MAX_RES  = blsplat_pkg::MAX_RES_DEF,
  parameter int MAX_MAPS = blsplat_pkg::MAX_MAPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  blsplat_pkg::splat_in_t             in_data,
  output logic                               out_valid,
  output blsplat_pkg::splat_out_t            out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blsplat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blsplat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blsplat_pkg::*;

  logic [RES_CFG_W-1:0]  res_cfg_r, res_cfg_nxt;
  logic [MAPS_CFG_W-1:0] maps_cfg_r, maps_cfg_nxt;

  logic   accept, front_ready, clearing;
  logic   q_push, q_full, q_pop, q_valid;
  ent_t   push_ent, pop_ent;

  // The register file is always ready; writes land at the end of the cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    res_cfg_nxt  = res_cfg_r;
    maps_cfg_nxt = maps_cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RESOLUTION: res_cfg_nxt  = cfg_data[RES_CFG_W-1:0];
        CFG_MAP_COUNT:  maps_cfg_nxt = cfg_data[MAPS_CFG_W-1:0];
        default: begin
          res_cfg_nxt  = res_cfg_r;
          maps_cfg_nxt = maps_cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cfg_r  <= RES_CFG_W'(256);
      maps_cfg_r <= MAPS_CFG_W'(8);
    end else begin
      res_cfg_r  <= res_cfg_nxt;
      maps_cfg_r <= maps_cfg_nxt;
    end
  end

  // The front can take a new item in the same cycle it hands off the last entry of
  // the previous one; nothing is taken while the store is being cleared.
  assign busy   = clearing || !front_ready;
  assign accept = start && !busy;

  blsplat_front #(
    .MAX_RES  (MAX_RES),
    .MAX_MAPS (MAX_MAPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .res_cfg  (res_cfg_r),
    .maps_cfg (maps_cfg_r),
    .ready    (front_ready),
    .push     (q_push),
    .push_ent (push_ent),
    .full     (q_full)
  );

  blsplat_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .pop_ent  (pop_ent),
    .valid    (q_valid)
  );

  blsplat_back #(
    .MAX_RES  (MAX_RES),
    .MAX_MAPS (MAX_MAPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ent     (pop_ent),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/blsplat_checker.sv =====
// Port-level checks for the bilinear lightmap splat core, bound to the top level.
// Depends on blsplat_pkg and bilinear_lightmap_splat_core.
module blsplat_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input blsplat_pkg::splat_out_t out_data
);
  import blsplat_pkg::*;

  // The store clearing pass keeps the block busy right after reset.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // Every accepted transaction needs at least the multiply cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block took a transaction and was ready again at once");

  // Every item passes the multiply state before its last entry, so strobes never touch.
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in back-to-back cycles");

  // A rejected transaction reads and deposits nothing.
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rejected) |->
      (out_data.flux == '0 && out_data.taps_written == '0))
    else $error("rejected result carries flux or taps");

  // A splat deposits at most four taps and returns no flux.
  a_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.taps_written != '0) |->
      (out_data.taps_written <= TAPS_W'(4) && out_data.flux == '0))
    else $error("splat result out of range");

endmodule

bind bilinear_lightmap_splat_core blsplat_checker u_blsplat_checker (.*);
